// ----- rtl/rletga_pkg.sv -----
`default_nettype none

package rletga_pkg;

  // Widths of the counters, registers and result fields
  localparam int unsigned TotalWidth     = 40;
  localparam int unsigned ByteWidth      = 8;
  localparam int unsigned RatioWidth     = 16;
  localparam int unsigned LimitWidth     = 32;
  localparam int unsigned CfgIdxWidth    = 2;
  localparam int unsigned CountWidth     = 2;
  localparam int unsigned StatusWidth    = 2;
  // Span length and run length, at most 128
  localparam int unsigned LenWidth       = 8;
  localparam int unsigned BytesPerResult = 2;

  // Limit compare runs at the wider of the total and the limit
  localparam int unsigned CmpWidth  = (TotalWidth > LimitWidth) ? TotalWidth : LimitWidth;
  // Input total times ratio is built from two half-width partial products
  localparam int unsigned LoWidth   = TotalWidth / 2;
  localparam int unsigned HiWidth   = TotalWidth - LoWidth;
  localparam int unsigned PLoWidth  = LoWidth + RatioWidth;
  localparam int unsigned PHiWidth  = HiWidth + RatioWidth;
  localparam int unsigned ProdWidth = TotalWidth + RatioWidth;

  // PackBits no-op control byte
  localparam logic [ByteWidth-1:0] PbNoop = 8'h80;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_FORMAT    = 2'd0,
    CFG_OUT_LIMIT = 2'd1,
    CFG_RATIO     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FMT_PACKBITS = 1'b0,
    FMT_TARGA    = 1'b1
  } format_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_OK    = 2'd0,
    STAT_LIMIT = 2'd1,
    STAT_RATIO = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_LITERAL = 2'd1,
    PH_RUN     = 2'd2
  } phase_e;

  // What the byte at the input does, given the current state
  typedef enum logic [2:0] {
    KIND_CONTROL = 3'd0,
    KIND_LITERAL = 3'd1,
    KIND_RUN     = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_LIMIT   = 3'd4
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic ratio_chk;  // resolve ratio check and final status
    logic emit;       // load next result into the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  out_free;   // output register can take a result this cycle
    logic  emit_last;  // next result loaded is the final one
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rletga_ctrl.sv -----
`default_nettype none

module rletga_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  rletga_pkg::dp_stat_t      stat_i,
  output rletga_pkg::ctl_cmd_t      cmd_o
);
  import rletga_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CMP  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          case (stat_i.kind)
            KIND_CONTROL: state_d = S_IDLE;
            KIND_LITERAL: state_d = S_MUL;
            KIND_RUN:     state_d = S_MUL;
            default:      state_d = S_EMIT;
          endcase
        end
      end
      S_MUL: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.ratio_chk = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free && stat_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rletga_dpath.sv -----
`default_nettype none

module rletga_dpath (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_valid_i,
  input  wire  [rletga_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire  [rletga_pkg::LimitWidth-1:0]      cfg_data_i,
  input  wire  [rletga_pkg::ByteWidth-1:0]       in_byte_i,
  input  rletga_pkg::ctl_cmd_t                   cmd_i,
  output rletga_pkg::dp_stat_t                   stat_o,
  input  wire                                    out_stall_i,
  output logic                                   out_valid_o,
  output logic [rletga_pkg::ByteWidth-1:0]       out_byte_first_o,
  output logic [rletga_pkg::ByteWidth-1:0]       out_byte_second_o,
  output logic [rletga_pkg::CountWidth-1:0]      byte_count_o,
  output logic [rletga_pkg::StatusWidth-1:0]     status_o,
  output logic                                   last_o
);
  import rletga_pkg::*;

  function automatic logic [TotalWidth-1:0] sat_add(input logic [TotalWidth-1:0] a,
                                                    input logic [LenWidth-1:0]   b);
    logic [TotalWidth:0] s;
    s = {1'b0, a} + (TotalWidth + 1)'(b);
    sat_add = s[TotalWidth] ? '1 : s[TotalWidth-1:0];
  endfunction

  // Configuration
  format_e                 format_q;
  logic [LimitWidth-1:0]   out_limit_q;
  logic [RatioWidth-1:0]   ratio_q;

  // Decoder state
  phase_e                  phase_q, phase_d;
  logic [LenWidth-1:0]     pending_q, pending_d;
  logic [TotalWidth-1:0]   in_total_q, in_total_d;
  logic [TotalWidth-1:0]   out_total_q, out_total_d;
  status_e                 err_q, err_d;

  // Per-item work registers
  logic [ByteWidth-1:0]    run_val_q, run_val_d;
  logic [LenWidth-1:0]     emit_rem_q, emit_rem_d;
  status_e                 fin_st_q, fin_st_d;
  logic                    trunc_q, trunc_d;
  logic [PLoWidth-1:0]     prod_lo_q;
  logic [PHiWidth-1:0]     prod_hi_q;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [ByteWidth-1:0]    out_first_q, out_first_d;
  logic [ByteWidth-1:0]    out_second_q, out_second_d;
  logic [CountWidth-1:0]   out_cnt_q, out_cnt_d;
  status_e                 out_st_q, out_st_d;
  logic                    out_last_q, out_last_d;

  // Combinational terms
  logic                    limit_on;
  logic                    limit_hit;
  logic [CmpWidth-1:0]     remain;
  logic                    trunc;
  logic [LenWidth-1:0]     run_len;
  kind_e                   kind;
  logic [ProdWidth-1:0]    prod_sum;
  logic                    ratio_bad;
  logic [CountWidth-1:0]   emit_cnt;
  logic                    emit_last;
  logic                    out_free;

  // Output budget against the limit
  assign limit_on  = (out_limit_q != '0);
  assign limit_hit = limit_on && (CmpWidth'(out_total_q) >= CmpWidth'(out_limit_q));
  assign remain    = CmpWidth'(out_limit_q) - CmpWidth'(out_total_q);
  assign trunc     = limit_on && !limit_hit && (CmpWidth'(pending_q) > remain);
  assign run_len   = trunc ? remain[LenWidth-1:0] : pending_q;

  // Classify the byte at the input
  always_comb begin
    if (err_q != STAT_OK) begin
      kind = KIND_ERROR;
    end else begin
      case (phase_q)
        PH_LITERAL: kind = limit_hit ? KIND_LIMIT : KIND_LITERAL;
        PH_RUN:     kind = limit_hit ? KIND_LIMIT : KIND_RUN;
        default:    kind = KIND_CONTROL;
      endcase
    end
  end

  // Expansion check: output total above input total times ratio
  assign prod_sum  = ProdWidth'(prod_lo_q) + (ProdWidth'(prod_hi_q) << LoWidth);
  assign ratio_bad = (ratio_q != '0) && (out_total_q != '0) &&
                     (ProdWidth'(out_total_q) > prod_sum);

  // Result slicing
  assign emit_cnt  = (emit_rem_q >= LenWidth'(BytesPerResult)) ?
                     CountWidth'(BytesPerResult) : emit_rem_q[CountWidth-1:0];
  assign emit_last = (emit_rem_q <= LenWidth'(BytesPerResult));
  assign out_free  = !out_valid_q || !out_stall_i;

  assign stat_o.kind      = kind;
  assign stat_o.out_free  = out_free;
  assign stat_o.emit_last = emit_last;

  // Decoder state update
  always_comb begin
    phase_d     = phase_q;
    pending_d   = pending_q;
    in_total_d  = in_total_q;
    out_total_d = out_total_q;
    err_d       = err_q;
    run_val_d   = run_val_q;
    emit_rem_d  = emit_rem_q;
    fin_st_d    = fin_st_q;
    trunc_d     = trunc_q;

    if (cmd_i.accept) begin
      if (kind != KIND_ERROR) begin
        in_total_d = sat_add(in_total_q, LenWidth'(1));
      end
      case (kind)
        KIND_ERROR: begin
          fin_st_d   = err_q;
          emit_rem_d = '0;
        end
        KIND_LIMIT: begin
          err_d      = STAT_LIMIT;
          fin_st_d   = STAT_LIMIT;
          emit_rem_d = '0;
        end
        KIND_LITERAL: begin
          out_total_d = sat_add(out_total_q, LenWidth'(1));
          if (pending_q != '0) begin
            pending_d = pending_q - LenWidth'(1);
          end
          if (pending_q <= LenWidth'(1)) begin
            phase_d = PH_CONTROL;
          end
          run_val_d  = in_byte_i;
          emit_rem_d = LenWidth'(1);
          trunc_d    = 1'b0;
        end
        KIND_RUN: begin
          out_total_d = sat_add(out_total_q, run_len);
          pending_d   = pending_q - run_len;
          if (pending_q == run_len) begin
            phase_d = PH_CONTROL;
          end
          run_val_d  = in_byte_i;
          emit_rem_d = run_len;
          trunc_d    = trunc;
        end
        default: begin
          // control byte: set up the next span
          if (format_q == FMT_PACKBITS) begin
            if (!in_byte_i[ByteWidth-1]) begin
              phase_d   = PH_LITERAL;
              pending_d = in_byte_i + LenWidth'(1);
            end else if (in_byte_i == PbNoop) begin
              phase_d = PH_CONTROL;
            end else begin
              phase_d   = PH_RUN;
              pending_d = LenWidth'((ByteWidth + 1)'(257) - {1'b0, in_byte_i});
            end
          end else begin
            pending_d = LenWidth'(in_byte_i[ByteWidth-2:0]) + LenWidth'(1);
            phase_d   = in_byte_i[ByteWidth-1] ? PH_RUN : PH_LITERAL;
          end
        end
      endcase
    end

    // Final status of a literal or run; ratio failure wins over truncation
    if (cmd_i.ratio_chk) begin
      if (ratio_bad) begin
        err_d    = STAT_RATIO;
        fin_st_d = STAT_RATIO;
      end else if (trunc_q) begin
        err_d    = STAT_LIMIT;
        fin_st_d = STAT_LIMIT;
      end else begin
        fin_st_d = STAT_OK;
      end
    end

    if (cmd_i.emit) begin
      emit_rem_d = emit_rem_q - LenWidth'(emit_cnt);
    end
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    out_cnt_d    = out_cnt_q;
    out_st_d     = out_st_q;
    out_last_d   = out_last_q;
    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_cnt_d    = emit_cnt;
      out_first_d  = (emit_cnt != '0) ? run_val_q : '0;
      out_second_d = (emit_cnt == CountWidth'(BytesPerResult)) ? run_val_q : '0;
      out_st_d     = emit_last ? fin_st_q : STAT_OK;
      out_last_d   = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q    <= FMT_PACKBITS;
      out_limit_q <= '0;
      ratio_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FORMAT:    format_q    <= format_e'(cfg_data_i[0]);
        CFG_OUT_LIMIT: out_limit_q <= cfg_data_i;
        CFG_RATIO:     ratio_q     <= cfg_data_i[RatioWidth-1:0];
        default:       ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CONTROL;
      pending_q   <= '0;
      in_total_q  <= '0;
      out_total_q <= '0;
      err_q       <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pending_q   <= pending_d;
      in_total_q  <= in_total_d;
      out_total_q <= out_total_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and work registers; partial products track the input total
  always_ff @(posedge clk_i) begin
    run_val_q    <= run_val_d;
    emit_rem_q   <= emit_rem_d;
    fin_st_q     <= fin_st_d;
    trunc_q      <= trunc_d;
    prod_lo_q    <= PLoWidth'(in_total_q[LoWidth-1:0]) * PLoWidth'(ratio_q);
    prod_hi_q    <= PHiWidth'(in_total_q[TotalWidth-1:LoWidth]) * PHiWidth'(ratio_q);
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
    out_cnt_q    <= out_cnt_d;
    out_st_q     <= out_st_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_first_o  = out_first_q;
  assign out_byte_second_o = out_second_q;
  assign byte_count_o      = out_cnt_q;
  assign status_o          = out_st_q;
  assign last_o            = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/rle_packbits_tga_decoder_core.sv -----
// Control byte: taken, gives no result. Literal byte: take, multiply, ratio compare,
// load output register. Run data byte of length n: the same steps, then ceil(n/2)
// results of up to two bytes, one per cycle while the output is not stalled, set by
// the single output register; error and limit-reached bytes skip to loading that register.
// Reset is asynchronous, active low: clears state, counters, error and configuration
// at once, with no clearing pass.
`default_nettype none

module rle_packbits_tga_decoder_core (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire  [rletga_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire  [rletga_pkg::LimitWidth-1:0]      cfg_data_i,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire  [rletga_pkg::ByteWidth-1:0]       in_byte_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic [rletga_pkg::ByteWidth-1:0]       out_byte_first_o,
  output logic [rletga_pkg::ByteWidth-1:0]       out_byte_second_o,
  output logic [rletga_pkg::CountWidth-1:0]      byte_count_o,
  output logic [rletga_pkg::StatusWidth-1:0]     status_o,
  output logic                                   last_o
);
  import rletga_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Registers accept a write on any cycle
  assign cfg_ready_o = 1'b1;

  rletga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rletga_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_byte_i         (in_byte_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_byte_first_o  (out_byte_first_o),
    .out_byte_second_o (out_byte_second_o),
    .byte_count_o      (byte_count_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

// ----- test/rle_packbits_tga_decoder_core_test.sv -----
`timescale 1ns / 100ps

import rletga_pkg::*;

// Grammar constants
localparam logic [ByteWidth-1:0] LitMax   = 8'h7F;
localparam int                   RunBase  = 257;
localparam logic [63:0]          TotalMax = (64'd1 << TotalWidth) - 64'd1;

// One decoded result as seen on the output port
typedef struct packed {
  logic [ByteWidth-1:0]   first;
  logic [ByteWidth-1:0]   second;
  logic [CountWidth-1:0]  count;
  logic [StatusWidth-1:0] status;
  logic                   last;
} decoded_t;

// Tracks decoder state, predicts the decoded bytes of every accepted input byte
// and matches them against the results that come out.
class decode_tracker;
  format_e                fmt;
  logic [LimitWidth-1:0]  out_limit;
  logic [RatioWidth-1:0]  ratio;
  phase_e                 phase;
  logic [LenWidth-1:0]    pending;
  logic [ByteWidth-1:0]   run_value;
  logic [TotalWidth-1:0]  in_total;
  logic [TotalWidth-1:0]  out_total;
  status_e                err;
  decoded_t               decoded_due[$];
  int                     mismatches;
  int                     checked;
  int                     literals;
  int                     runs;
  int                     truncated;

  function new();
    fmt       = FMT_PACKBITS;
    out_limit = '0;
    ratio     = '0;
    phase     = PH_CONTROL;
    pending   = '0;
    run_value = '0;
    in_total  = '0;
    out_total = '0;
    err       = STAT_OK;
  endfunction

  function void write_reg(cfg_idx_e idx, logic [LimitWidth-1:0] data);
    case (idx)
      CFG_FORMAT:    fmt = format_e'(data[0]);
      CFG_OUT_LIMIT: out_limit = data;
      CFG_RATIO:     ratio = data[RatioWidth-1:0];
      default: ;
    endcase
  endfunction

  // Totals saturate instead of wrapping
  function logic [TotalWidth-1:0] add_sat(logic [TotalWidth-1:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = 65'(a) + 65'(b);
    if (sum > 65'(TotalMax)) return TotalMax[TotalWidth-1:0];
    return sum[TotalWidth-1:0];
  endfunction

  // output > input * ratio, done without the wide product
  function bit ratio_over();
    logic [63:0] outs;
    outs = 64'(out_total);
    if (ratio == '0 || outs == '0) return 1'b0;
    return 64'(in_total) <= (outs - 64'd1) / 64'(ratio);
  endfunction

  function void push(logic [ByteWidth-1:0] a, logic [ByteWidth-1:0] b,
                     logic [CountWidth-1:0] c, status_e st, logic l);
    decoded_t r;
    r.first  = a;
    r.second = b;
    r.count  = c;
    r.status = st;
    r.last   = l;
    decoded_due.push_back(r);
  endfunction

  function void absorb_byte(logic [ByteWidth-1:0] b);
    logic [63:0]           n;
    logic [63:0]           rem;
    logic [CountWidth-1:0] c;
    bit                    trunc;
    status_e               st;
    trunc = 1'b0;
    st    = STAT_OK;
    // sticky error: every byte just reports it
    if (err != STAT_OK) begin
      push('0, '0, '0, err, 1'b1);
      return;
    end
    in_total = add_sat(in_total, 64'd1);
    case (phase)
      PH_LITERAL: begin
        if (out_limit != '0 && 64'(out_total) >= 64'(out_limit)) begin
          err = STAT_LIMIT;
          push('0, '0, '0, STAT_LIMIT, 1'b1);
          return;
        end
        out_total = add_sat(out_total, 64'd1);
        if (pending != '0) pending--;
        if (pending == '0) phase = PH_CONTROL;
        if (ratio_over()) begin
          err = STAT_RATIO;
          st  = STAT_RATIO;
        end
        literals++;
        push(b, '0, CountWidth'(1), st, 1'b1);
      end
      PH_RUN: begin
        run_value = b;
        n = 64'(pending);
        if (out_limit != '0) begin
          rem = (64'(out_limit) > 64'(out_total)) ? 64'(out_limit) - 64'(out_total) : 64'd0;
          if (rem == 64'd0) begin
            err = STAT_LIMIT;
            push('0, '0, '0, STAT_LIMIT, 1'b1);
            return;
          end
          if (n > rem) begin
            n     = rem;
            trunc = 1'b1;
          end
        end
        out_total = add_sat(out_total, n);
        pending   = pending - n[LenWidth-1:0];
        if (pending == '0) phase = PH_CONTROL;
        // ratio failure wins over truncation
        if (ratio_over()) begin
          err = STAT_RATIO;
          st  = STAT_RATIO;
        end else if (trunc) begin
          err = STAT_LIMIT;
          st  = STAT_LIMIT;
          truncated++;
        end
        runs++;
        if (n == 64'd0) begin
          push('0, '0, '0, st, 1'b1);
          return;
        end
        while (n > 64'd0) begin
          c = (n >= 64'(BytesPerResult)) ? CountWidth'(BytesPerResult) : CountWidth'(n);
          push(run_value, (c == CountWidth'(BytesPerResult)) ? run_value : '0, c,
               (n == 64'(c)) ? st : STAT_OK, n == 64'(c));
          n -= 64'(c);
        end
      end
      default: begin
        // control byte: sets up the next token, no result
        if (fmt == FMT_PACKBITS) begin
          if (b <= LitMax) begin
            phase   = PH_LITERAL;
            pending = b + 8'd1;
          end else if (b == PbNoop) begin
            phase = PH_CONTROL;
          end else begin
            phase   = PH_RUN;
            pending = LenWidth'(RunBase - int'(b));
          end
        end else begin
          pending = {1'b0, b[ByteWidth-2:0]} + 8'd1;
          phase   = b[ByteWidth-1] ? PH_RUN : PH_LITERAL;
        end
      end
    endcase
  endfunction

  task report_mismatch(string what);
    if (mismatches < 40) $display("MISMATCH %s", what);
    mismatches++;
  endtask

  task check_result(decoded_t got);
    decoded_t want;
    if (decoded_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result %02h %02h n=%0d st=%0d last=%0d",
                                got.first, got.second, got.count, got.status, got.last));
      return;
    end
    want = decoded_due.pop_front();
    checked++;
    if (got !== want)
      report_mismatch($sformatf(
        "result %0d: got %02h %02h n=%0d st=%0d last=%0d, want %02h %02h n=%0d st=%0d last=%0d",
        checked, got.first, got.second, got.count, got.status, got.last,
        want.first, want.second, want.count, want.status, want.last));
  endtask
endclass

module rle_packbits_tga_decoder_core_test;

  localparam int IdleLimit    = 2000;
  localparam int LongHold     = 200;
  localparam int SettleCycles = 12;
  localparam int SideIn       = 0;
  localparam int SideOut      = 1;

  typedef enum int {
    END_LIMIT_HIT,
    END_TRUNCATE,
    END_RATIO,
    END_RATIO_TRUNC
  } finale_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = CFG_FORMAT;
  logic [LimitWidth-1:0]  cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [ByteWidth-1:0]   in_byte_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [ByteWidth-1:0]   out_byte_first_o;
  logic [ByteWidth-1:0]   out_byte_second_o;
  logic [CountWidth-1:0]  byte_count_o;
  logic [StatusWidth-1:0] status_o;
  logic                   last_o;

  decode_tracker board;
  bit            hold_long;
  int            quiet_left [2];
  int            sent;
  int            mid_token_swaps;

  rle_packbits_tga_decoder_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_first_o  (out_byte_first_o),
    .out_byte_second_o (out_byte_second_o),
    .byte_count_o      (byte_count_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle cycles before a transfer, with stretches of back-to-back traffic
  function automatic int draw_wait(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Control bytes for the format currently set
  function automatic logic [ByteWidth-1:0] lit_ctrl(input int len);
    return ByteWidth'(len - 1);
  endfunction

  function automatic logic [ByteWidth-1:0] run_ctrl(input int len);
    if (board.fmt == FMT_TARGA) return 8'h80 | ByteWidth'(len - 1);
    return ByteWidth'(RunBase - len);
  endfunction

  // One input transfer; valid stays high afterward unless a gap follows
  task automatic send_byte(input logic [ByteWidth-1:0] b);
    int gap;
    gap = draw_wait(SideIn);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.absorb_byte(b);
    sent++;
  endtask

  // Stop sending and wait for every predicted result, plus control-byte latency
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.decoded_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Feed data until the decoder is back at a token boundary
  task automatic finish_token();
    while (board.phase != PH_CONTROL) send_byte(ByteWidth'($urandom));
  endtask

  task automatic cfg_transfer(input cfg_idx_e idx, input logic [LimitWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic write_regs(input format_e f, input logic [LimitWidth-1:0] lim,
                            input logic [RatioWidth-1:0] rat);
    cfg_transfer(CFG_FORMAT, LimitWidth'(f));
    cfg_transfer(CFG_OUT_LIMIT, lim);
    cfg_transfer(CFG_RATIO, LimitWidth'(rat));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed tokens with random content, some noise, PackBits no-ops and cut spans
  task automatic send_stream(input int items);
    int count;
    int pick;
    int len;
    int cut;
    count = 0;
    while (count < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_byte(ByteWidth'($urandom));
        count++;
      end else if (pick < 48) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
        send_byte(lit_ctrl(len));
        repeat (len) send_byte(ByteWidth'($urandom));
        count += len + 1;
      end else if (pick < 92) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 128) : $urandom_range(2, 9);
        if (board.fmt == FMT_TARGA && $urandom_range(0, 3) == 0) len = 1;
        send_byte(run_ctrl(len));
        send_byte(ByteWidth'($urandom));
        count += 2;
      end else if (board.fmt == FMT_PACKBITS && pick < 96) begin
        send_byte(PbNoop);
      end else begin
        // span cut short: the next control byte lands as data
        len = $urandom_range(2, 6);
        cut = $urandom_range(0, len - 1);
        send_byte(lit_ctrl(len));
        repeat (cut) send_byte(ByteWidth'($urandom));
        count += cut + 1;
      end
    end
  endtask

  // Output side: random stalls, one long hold-off on request
  initial begin : receiver
    decoded_t got;
    int       hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        hold      = LongHold;
        hold_long = 1'b0;
      end else begin
        hold = draw_wait(SideOut);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.first  = out_byte_first_o;
      got.second = out_byte_second_o;
      got.count  = byte_count_o;
      got.status = status_o;
      got.last   = last_o;
      board.check_result(got);
    end
  end

  // Ends the run if no transfer of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("rle_packbits_tga_decoder_core verification failed");
    $finish;
  end

  initial begin : stimulus
    finale_e finale;
    int      guard;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // PackBits, no limits: literals, no-op, shortest and longest runs, odd run
    write_regs(FMT_PACKBITS, '0, '0);
    send_byte(lit_ctrl(1));
    send_byte(8'h00);
    send_byte(PbNoop);
    send_byte(run_ctrl(128));
    send_byte(8'hFF);
    send_byte(run_ctrl(2));
    send_byte(8'hA5);
    send_byte(run_ctrl(3));
    send_byte(8'h5A);
    send_byte(lit_ctrl(2));
    send_byte(8'hFF);
    send_byte(8'h80);
    send_stream(110);

    // format changed between a run's control byte and its data byte
    finish_token();
    send_byte(run_ctrl(126));
    drain_results();
    write_regs(FMT_TARGA, '1, '1);
    mid_token_swaps++;
    send_byte(8'h3C);

    // Targa: single literal, run of one, run of 128
    send_byte(lit_ctrl(1));
    send_byte(8'h01);
    send_byte(run_ctrl(1));
    send_byte(8'h7E);
    send_byte(run_ctrl(128));
    send_byte(8'h00);
    send_stream(60);

    // receiver holds off while long runs keep coming in
    finish_token();
    hold_long = 1'b1;
    repeat (4) begin
      send_byte(run_ctrl(128));
      send_byte(ByteWidth'($urandom));
    end
    send_stream(60);

    // literal span interrupted by a format change
    finish_token();
    send_byte(lit_ctrl(3));
    send_byte(ByteWidth'($urandom));
    drain_results();
    write_regs(FMT_PACKBITS, board.out_total[LimitWidth-1:0] + 32'h0010_0000, 16'd64);
    mid_token_swaps++;
    send_byte(ByteWidth'($urandom));
    send_byte(ByteWidth'($urandom));
    send_stream(60);
    drain_results();
    send_stream(60);

    finish_token();
    drain_results();
    write_regs(FMT_TARGA, '0, '0);
    send_stream(70);

    // close with one sticky error, chosen at random
    finish_token();
    drain_results();
    finale = finale_e'($urandom_range(END_LIMIT_HIT, END_RATIO_TRUNC));
    case (finale)
      END_LIMIT_HIT: begin
        write_regs(board.fmt, board.out_total[LimitWidth-1:0], '0);
        if ($urandom_range(0, 1) == 0) send_byte(lit_ctrl(1));
        else send_byte(run_ctrl(2));
        send_byte(ByteWidth'($urandom));
      end
      END_TRUNCATE: begin
        write_regs(board.fmt, board.out_total[LimitWidth-1:0] + $urandom_range(1, 9), '0);
        send_byte(run_ctrl(128));
        send_byte(ByteWidth'($urandom));
      end
      END_RATIO: begin
        write_regs(board.fmt, '0, 16'd1);
        guard = 0;
        while (board.err == STAT_OK && guard < 40) begin
          send_byte(run_ctrl(128));
          send_byte(ByteWidth'($urandom));
          guard++;
        end
      end
      default: begin
        write_regs(board.fmt, board.out_total[LimitWidth-1:0] + $urandom_range(1, 9), 16'd1);
        send_byte(run_ctrl(128));
        send_byte(ByteWidth'($urandom));
      end
    endcase
    repeat (10) send_byte(ByteWidth'($urandom));
    drain_results();

    $display("covered %0d input bytes, %0d results: %0d literal bytes, %0d runs, %0d truncated",
             sent, board.checked, board.literals, board.runs, board.truncated);
    $display("both grammars, %0d mid-token format changes, final sticky status %0d",
             mid_token_swaps, board.err);
    if (board.mismatches == 0 && board.decoded_due.size() == 0)
      $display("rle_packbits_tga_decoder_core verification clean");
    else
      $display("rle_packbits_tga_decoder_core verification failed");
    $finish;
  end

endmodule
